>>> design/servo_demand_command_decode_defines.svh
// ---------------------------------------------------------------------------
// Servo demand command decoder: assertion macros
// Shared property shorthands for the decoder's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef SERVO_DEMAND_COMMAND_DECODE_DEFINES_SVH
`define SERVO_DEMAND_COMMAND_DECODE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SDCD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sdcd_pkg.sv
// ---------------------------------------------------------------------------
// Servo demand command decoder package
// Types, register map, mode codes, microcode format and the control store.
// ---------------------------------------------------------------------------
package sdcd_pkg;

  // Configuration register map (word index on the APB port).
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_MAX_CURRENT = 3'd0;
  localparam logic [2:0] REG_UNCAL_LIMIT = 3'd1;
  localparam logic [2:0] REG_POS_SCALE   = 3'd2;
  localparam logic [2:0] REG_HOME_OFFSET = 3'd3;
  localparam logic [2:0] REG_STOP_MIN    = 3'd4;
  localparam logic [2:0] REG_STOP_MAX    = 3'd5;
  localparam logic [2:0] REG_STOP_ENABLE = 3'd6;
  localparam logic [2:0] REG_UPDATE_RATE = 3'd7;

  // Mode codes taken from bits 5..2 of the joint mode byte.
  localparam logic [3:0] MODE_TORQUE   = 4'd2;
  localparam logic [3:0] MODE_VELOCITY = 4'd3;
  localparam logic [3:0] MODE_POSITION = 4'd4;

  // Result update kinds.
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_POSITION = 2'd1;
  localparam logic [1:0] KIND_VELOCITY = 2'd2;
  localparam logic [1:0] KIND_TORQUE   = 2'd3;

  // Width of the registered product; every product used fits in it.
  localparam int PROD_W = 50;

  // Sequencer program counter.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_REJECT  = 5'd10;
  localparam logic [STEP_W-1:0] ST_NOT_POS = 5'd11;
  localparam logic [STEP_W-1:0] ST_NOT_VEL = 5'd15;
  localparam logic [STEP_W-1:0] ST_BAD     = 5'd19;
  localparam logic [STEP_W-1:0] LAST_STEP  = 5'd19;

  typedef struct packed {
    logic [15:0]        max_current;
    logic [15:0]        uncal_limit;
    logic [31:0]        position_scale;
    logic signed [31:0] home_offset;
    logic signed [31:0] stop_min;
    logic signed [31:0] stop_max;
    logic               stop_enable;
    logic [15:0]        update_rate;
  } cfg_t;

  // Request payload, lowest field last.
  typedef struct packed {
    logic [6:0]         pad;
    logic               homed;
    logic [15:0]        torque_limit;
    logic signed [15:0] demand;
    logic [7:0]         stamp;
  } in_data_t;

  // Result payload, lowest field last.
  typedef struct packed {
    logic [3:0]         pad;
    logic               timer_restart;
    logic signed [16:0] demand_torque;
    logic signed [31:0] demand_velocity;
    logic signed [31:0] demand_position;
    logic [15:0]        current_limit;
    logic               bad_mode;
    logic               accepted;
  } out_data_t;

  // Microcode fields.
  typedef enum logic [1:0] {MA_TLIM, MA_DEMAND, MA_DIFF} mul_a_e;
  typedef enum logic [1:0] {MB_MAXCUR, MB_SCALE, MB_RATE} mul_b_e;
  typedef enum logic [3:0] {
    OP_NONE, OP_CUR, OP_PSAT, OP_POFS, OP_CLAMP, OP_DIFF, OP_VEL, OP_VDIR, OP_TRQ
  } op_e;
  typedef enum logic [2:0] {C_NEVER, C_NOT_POS, C_NOT_VEL, C_NOT_TRQ, C_REJECT} cond_e;
  typedef enum logic [2:0] {RES_POS, RES_VEL, RES_TRQ, RES_BAD, RES_REJ} res_e;

  typedef struct packed {
    mul_a_e            mul_a;
    mul_b_e            mul_b;
    logic              mul_en;
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              done;
    res_e              res;
  } ucode_t;

  localparam ucode_t UC_NOP = '{
    mul_a: MA_TLIM, mul_b: MB_MAXCUR, mul_en: 1'b0, op: OP_NONE,
    cond: C_NEVER, target: '0, done: 1'b0, res: RES_BAD
  };

  // Control store: one control word per step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = UC_NOP;
    case (step)
      // Current limit product, then dispatch on the mode.
      5'd0: begin
        w.mul_a = MA_TLIM; w.mul_b = MB_MAXCUR; w.mul_en = 1'b1;
      end
      5'd1: begin
        w.op = OP_CUR; w.cond = C_NOT_POS; w.target = ST_NOT_POS;
      end
      // Position mode.
      5'd2: begin
        w.mul_a = MA_DEMAND; w.mul_b = MB_SCALE; w.mul_en = 1'b1;
        w.cond = C_REJECT; w.target = ST_REJECT;
      end
      5'd3: w.op = OP_PSAT;
      5'd4: w.op = OP_POFS;
      5'd5: w.op = OP_CLAMP;
      5'd6: w.op = OP_DIFF;
      5'd7: begin
        w.mul_a = MA_DIFF; w.mul_b = MB_RATE; w.mul_en = 1'b1;
      end
      5'd8: w.op = OP_VEL;
      5'd9: begin
        w.done = 1'b1; w.res = RES_POS;
      end
      5'd10: begin
        w.done = 1'b1; w.res = RES_REJ;
      end
      // Velocity mode.
      5'd11: begin
        w.cond = C_NOT_VEL; w.target = ST_NOT_VEL;
      end
      5'd12: begin
        w.mul_a = MA_DEMAND; w.mul_b = MB_SCALE; w.mul_en = 1'b1;
      end
      5'd13: w.op = OP_VDIR;
      5'd14: begin
        w.done = 1'b1; w.res = RES_VEL;
      end
      // Torque mode.
      5'd15: begin
        w.cond = C_NOT_TRQ; w.target = ST_BAD;
      end
      5'd16: begin
        w.mul_a = MA_DEMAND; w.mul_b = MB_MAXCUR; w.mul_en = 1'b1;
      end
      5'd17: w.op = OP_TRQ;
      5'd18: begin
        w.done = 1'b1; w.res = RES_TRQ;
      end
      default: begin
        w.done = 1'b1; w.res = RES_BAD;
      end
    endcase
    return w;
  endfunction

  // Saturate a product-width value to 32 bits signed.
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[PROD_W-1:31]) || !(|v[PROD_W-1:31])) begin
      r = v[31:0];
    end else if (v[PROD_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // Magnitude divided by 32767, truncated and saturated to 65535. The input
  // is split at bit 15 twice, using 32768 = 32767 + 1, so that one final
  // compare and increment completes the quotient.
  function automatic logic [15:0] div32767_sat(input logic [31:0] x);
    logic [16:0] q0;
    logic [17:0] r0;
    logic [2:0]  a;
    logic [17:0] q1;
    logic [15:0] r1;
    logic [15:0] r;
    q0 = x[31:15];
    r0 = 18'(x[14:0]) + 18'(q0);
    a  = r0[17:15];
    q1 = 18'(q0) + 18'(a);
    r1 = 16'(r0[14:0]) + 16'(a);
    if (r1 >= 16'd32767) begin
      q1 = q1 + 18'd1;
    end
    if (q1 > 18'd65535) begin
      r = 16'hffff;
    end else begin
      r = q1[15:0];
    end
    return r;
  endfunction

endpackage

>>> design/sdcd_datapath.sv
// ---------------------------------------------------------------------------
// Servo demand command decoder datapath
// Shared multiplier, saturating adders, end-stop clamp, torque divider and
// the position history, all driven by the sequencer's control word.
// ---------------------------------------------------------------------------
module sdcd_datapath import sdcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ucode_t             ctrl_i,
  input  logic               exec_i,
  input  logic               commit_i,
  input  cfg_t               cfg_i,
  input  in_data_t           item_i,
  input  logic               calib_i,
  output logic [15:0]        cur_o,
  output logic signed [31:0] pos_o,
  output logic signed [31:0] vel_o,
  output logic signed [16:0] trq_o
);

  logic signed [32:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [65:0]       mul_full;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] neg_prod;
  logic signed [PROD_W-1:0] ofs_sum;
  logic signed [31:0]       p_q, p_d, p_lo;
  logic signed [32:0]       diff_q, diff_d;
  logic [15:0]              cur_q, cur_d, cur_raw;
  logic signed [31:0]       vel_q, vel_d;
  logic signed [16:0]       trq_q, trq_d;
  logic [15:0]              trq_mag;
  logic [7:0]               last_stamp_q;
  logic signed [31:0]       last_pos_q;
  logic                     stamp_next;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctrl_i.mul_a)
      MA_TLIM:   mul_a = $signed({17'b0, item_i.torque_limit});
      MA_DEMAND: mul_a = $signed({{17{item_i.demand[15]}}, item_i.demand});
      MA_DIFF:   mul_a = diff_q;
      default:   mul_a = '0;
    endcase
    case (ctrl_i.mul_b)
      MB_MAXCUR: mul_b = $signed({17'b0, cfg_i.max_current});
      MB_SCALE:  mul_b = $signed({1'b0, cfg_i.position_scale});
      MB_RATE:   mul_b = $signed({17'b0, cfg_i.update_rate});
      default:   mul_b = '0;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (exec_i && ctrl_i.mul_en) begin
      prod_q <= mul_full[PROD_W-1:0];
    end
  end

  // Intermediate terms used by the operations below.
  assign cur_raw    = prod_q[31:16];
  assign neg_prod   = -prod_q;
  assign ofs_sum    = {{(PROD_W-32){p_q[31]}}, p_q}
                    + {{(PROD_W-32){cfg_i.home_offset[31]}}, cfg_i.home_offset};
  assign p_lo       = (p_q < cfg_i.stop_min) ? cfg_i.stop_min : p_q;
  assign stamp_next = ((last_stamp_q + 8'd1) == item_i.stamp) && (cfg_i.update_rate != 16'd0);
  assign trq_mag    = div32767_sat(prod_q[PROD_W-1] ? neg_prod[31:0] : prod_q[31:0]);

  // Operation of the current step.
  always_comb begin
    cur_d  = cur_q;
    p_d    = p_q;
    diff_d = diff_q;
    vel_d  = vel_q;
    trq_d  = trq_q;
    if (exec_i) begin
      case (ctrl_i.op)
        OP_CUR: begin
          cur_d = (!item_i.homed && (cur_raw > cfg_i.uncal_limit)) ? cfg_i.uncal_limit
                                                                   : cur_raw;
        end
        OP_PSAT: p_d = sat32(prod_q);
        OP_POFS: begin
          if (calib_i) begin
            p_d = sat32(ofs_sum);
          end
        end
        OP_CLAMP: begin
          if (item_i.homed && cfg_i.stop_enable) begin
            p_d = (p_lo > cfg_i.stop_max) ? cfg_i.stop_max : p_lo;
          end
        end
        OP_DIFF: diff_d = {p_q[31], p_q} - {last_pos_q[31], last_pos_q};
        OP_VEL:  vel_d  = stamp_next ? sat32(prod_q) : 32'sd0;
        OP_VDIR: vel_d  = sat32(prod_q);
        OP_TRQ: begin
          trq_d = prod_q[PROD_W-1] ? -$signed({1'b0, trq_mag}) : $signed({1'b0, trq_mag});
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    p_q    <= p_d;
    diff_q <= diff_d;
    vel_q  <= vel_d;
    trq_q  <= trq_d;
  end

  // History of the last accepted position command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
      last_pos_q   <= '0;
    end else if (commit_i) begin
      last_stamp_q <= item_i.stamp;
      last_pos_q   <= p_q;
    end
  end

  assign cur_o = cur_q;
  assign pos_o = p_q;
  assign vel_o = vel_q;
  assign trq_o = trq_q;

endmodule

>>> design/servo_demand_command_decode.sv
// ---------------------------------------------------------------------------
// Servo demand command decoder
// Decodes one servo demand command per request into current limit, position,
// velocity or torque demands under control of a microcoded sequencer.
// ---------------------------------------------------------------------------
// A new request can be taken from the cycle after the previous result is loaded
// into the output register, so requests are not overlapped; the program steps
// through one shared 33x33 multiplier. Reset is asynchronous and active low; it
// clears the configuration, sequencer and output-valid registers to their reset
// values and the position history to zero.
`include "servo_demand_command_decode_defines.svh"

module servo_demand_command_decode import sdcd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Command stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [47:0]         s_axis_tdata_i,  // stamp, demand, torque_limit, homed
  input  logic [7:0]          s_axis_tuser_i,  // joint_mode
  // Result stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [103:0]        m_axis_tdata_o,  // accepted, bad_mode, current_limit,
                                               // demand_position, demand_velocity,
                                               // demand_torque, timer_restart
  output logic [1:0]          m_axis_tuser_o,  // update_kind
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [31:0] POS_SCALE_RST = 32'(64'd1 << FRAC_BITS);

  cfg_t              cfg_q;
  logic              cfg_wr;
  logic [2:0]        reg_idx;
  in_data_t          item_q;
  logic [7:0]        jmode_q;
  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  ucode_t            uc;
  logic              jump;
  logic              fire;
  logic              s_hs;
  logic [3:0]        mode_code;
  logic              calib;
  logic              m_valid_q;
  out_data_t         out_q, out_d;
  logic [1:0]        kind_q, kind_d;
  logic [15:0]       dp_cur;
  logic signed [31:0] dp_pos;
  logic signed [31:0] dp_vel;
  logic signed [16:0] dp_trq;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_current    <= 16'd20000;
      cfg_q.uncal_limit    <= 16'd4000;
      cfg_q.position_scale <= POS_SCALE_RST;
      cfg_q.home_offset    <= '0;
      cfg_q.stop_min       <= '0;
      cfg_q.stop_max       <= '0;
      cfg_q.stop_enable    <= 1'b0;
      cfg_q.update_rate    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAX_CURRENT: cfg_q.max_current    <= pwdata[15:0];
        REG_UNCAL_LIMIT: cfg_q.uncal_limit    <= pwdata[15:0];
        REG_POS_SCALE:   cfg_q.position_scale <= pwdata;
        REG_HOME_OFFSET: cfg_q.home_offset    <= $signed(pwdata);
        REG_STOP_MIN:    cfg_q.stop_min       <= $signed(pwdata);
        REG_STOP_MAX:    cfg_q.stop_max       <= $signed(pwdata);
        REG_STOP_ENABLE: cfg_q.stop_enable    <= pwdata[0];
        REG_UPDATE_RATE: cfg_q.update_rate    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_MAX_CURRENT: prdata = {16'b0, cfg_q.max_current};
      REG_UNCAL_LIMIT: prdata = {16'b0, cfg_q.uncal_limit};
      REG_POS_SCALE:   prdata = cfg_q.position_scale;
      REG_HOME_OFFSET: prdata = cfg_q.home_offset;
      REG_STOP_MIN:    prdata = cfg_q.stop_min;
      REG_STOP_MAX:    prdata = cfg_q.stop_max;
      REG_STOP_ENABLE: prdata = {31'b0, cfg_q.stop_enable};
      REG_UPDATE_RATE: prdata = {16'b0, cfg_q.update_rate};
      default:         prdata = '0;
    endcase
  end

  // Request capture.
  assign s_axis_tready_o = !busy_q;
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      item_q  <= s_axis_tdata_i;
      jmode_q <= s_axis_tuser_i;
    end
  end

  // Sequencer: fetch, branch condition and step counter.
  assign uc        = ucode_rom(step_q);
  assign mode_code = jmode_q[5:2];
  assign calib     = jmode_q[0];

  always_comb begin
    case (uc.cond)
      C_NOT_POS: jump = (mode_code != MODE_POSITION);
      C_NOT_VEL: jump = (mode_code != MODE_VELOCITY);
      C_NOT_TRQ: jump = (mode_code != MODE_TORQUE);
      C_REJECT:  jump = calib && !item_q.homed;
      default:   jump = 1'b0;
    endcase
  end

  assign fire = busy_q && uc.done && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (s_hs) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (uc.done) begin
        if (fire) begin
          busy_q <= 1'b0;
          step_q <= '0;
        end
      end else if (jump) begin
        step_q <= uc.target;
      end else begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  sdcd_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (uc),
    .exec_i   (busy_q),
    .commit_i (fire && (uc.res == RES_POS)),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .calib_i  (calib),
    .cur_o    (dp_cur),
    .pos_o    (dp_pos),
    .vel_o    (dp_vel),
    .trq_o    (dp_trq)
  );

  // Result assembly by outcome.
  always_comb begin
    out_d = '0;
    out_d.accepted      = (uc.res != RES_REJ);
    out_d.bad_mode      = (uc.res == RES_BAD);
    out_d.current_limit = dp_cur;
    case (uc.res)
      RES_POS: begin
        kind_d                = KIND_POSITION;
        out_d.demand_position = dp_pos;
        out_d.demand_velocity = dp_vel;
        out_d.timer_restart   = 1'b1;
      end
      RES_VEL: begin
        kind_d                = KIND_VELOCITY;
        out_d.demand_velocity = dp_vel;
      end
      RES_TRQ: begin
        kind_d              = KIND_TORQUE;
        out_d.demand_torque = dp_trq;
      end
      default: kind_d = KIND_NONE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q  <= out_d;
      kind_q <= kind_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = kind_q;

  // Checks on the sequencer and result encoding.
  `SDCD_ASSERT_NOW(a_idle_at_entry, clk_i, rst_ni, !busy_q, step_q == '0,
    "sequencer left its entry step while idle")
  `SDCD_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, s_hs, busy_q && (step_q == '0),
    "accepted request did not start the program")
  `SDCD_ASSERT_NEXT(a_fire_ends, clk_i, rst_ni, fire, !busy_q && m_valid_q,
    "result load did not release the sequencer")
  `SDCD_ASSERT_NOW(a_step_range, clk_i, rst_ni, busy_q, step_q <= LAST_STEP,
    "step counter outside the program")
  `SDCD_ASSERT_NOW(a_reject_clean, clk_i, rst_ni, m_valid_q && !out_q.accepted,
    (kind_q == KIND_NONE) && !out_q.timer_restart && (out_q.demand_position == 32'sd0),
    "rejected request carries a demand")

endmodule
